// File: src/ssr_pkg.sv
// Shared constants, types and helpers of the servo slew limiter.
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

   localparam int CHANNELS    = 4;
   localparam int MAX_RESULTS = 4;

   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int CMD_W   = 2;
   localparam int CHF_W   = 4;
   localparam int DEG_W   = 8;
   localparam int SPD_W   = 16;
   localparam int POS_W   = 18;
   localparam int PULSE_W = 12;

   localparam logic [DEG_W-1:0]   MAX_ANGLE    = 8'd180;
   localparam logic [DEG_W-1:0]   CENTER_ANGLE = 8'd90;
   localparam logic [POS_W-1:0]   CENTER_MDEG  = 18'd90000;
   localparam logic [POS_W-1:0]   MDEG_PER_DEG = 18'd1000;
   localparam logic [PULSE_W-1:0] PULSE_BASE   = 12'd500;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_NOW  = 2'd0,
      CMD_SET_RAMP = 2'd1,
      CMD_READ     = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_STEP,
      ST_ROUND,
      ST_PULSE,
      ST_EMIT
   } state_type;

   // One channel's entry in the state memory.
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [DEG_W-1:0] target;
      logic [SPD_W-1:0] speed;
      logic [DEG_W-1:0] shown;
   } word_type;

   typedef struct packed {
      logic            rd_en;
      logic [CH_W-1:0] rd_addr;
      logic            wr_en;
      logic [CH_W-1:0] wr_addr;
   } mem_ctl_type;

   localparam word_type RESET_WORD = '{
      position: CENTER_MDEG,
      target:   CENTER_ANGLE,
      speed:    '0,
      shown:    CENTER_ANGLE
   };

   // Degrees to millidegrees; the widest input stays below 2**POS_W.
   function automatic logic [POS_W-1:0] mdeg_of(input logic [DEG_W-1:0] deg);
      return POS_W'(deg) * MDEG_PER_DEG;
   endfunction

endpackage

`default_nettype wire

// File: src/ssr_if.sv
// Request and response channel interfaces of the servo slew limiter.
`timescale 1ns / 1ps
`default_nettype none

interface ssr_req_if;
   logic                        valid;
   logic                        ready;
   logic [ssr_pkg::CMD_W-1:0]   cmd;
   logic [ssr_pkg::CHF_W-1:0]   channel;
   logic [ssr_pkg::DEG_W-1:0]   angle;
   logic [ssr_pkg::SPD_W-1:0]   speed;

   modport source(output valid, output cmd, output channel, output angle, output speed,
                  input ready);
   modport sink(input valid, input cmd, input channel, input angle, input speed,
                output ready);
endinterface

interface ssr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ssr_pkg::CHF_W-1:0]   out_channel;
   logic [ssr_pkg::PULSE_W-1:0] pwm_high_us;
   logic [ssr_pkg::DEG_W-1:0]   out_angle;
   logic                        drive;
   logic                        last;

   modport source(output valid, output out_channel, output pwm_high_us, output out_angle,
                  output drive, output last, input ready);
   modport sink(input valid, input out_channel, input pwm_high_us, input out_angle,
                input drive, input last, output ready);
endinterface

`default_nettype wire

// File: src/ssr_state_mem.sv
// Per-channel state memory with registered read data and reset-value valid bits.
`timescale 1ns / 1ps
`default_nettype none

module ssr_state_mem (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ssr_pkg::mem_ctl_type ctl,
   input  wire ssr_pkg::word_type  wr_data,
   output ssr_pkg::word_type       rd_data
);

   ssr_pkg::word_type                 mem_ff [ssr_pkg::CHANNELS];
   logic [ssr_pkg::CHANNELS-1:0]      valid_ff;
   ssr_pkg::word_type                 rd_word_ff;
   logic                              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem_ff[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.rd_addr];
         end
      end
   end

   // An entry never written reads as its reset contents.
   assign rd_data = rd_valid_ff ? rd_word_ff : ssr_pkg::RESET_WORD;

endmodule

`default_nettype wire

// File: src/ssr_slew.sv
// One millisecond slew step of a channel position toward its target.
`timescale 1ns / 1ps
`default_nettype none

module ssr_slew (
   input  wire logic [ssr_pkg::POS_W-1:0] pos_mdeg,
   input  wire logic [ssr_pkg::POS_W-1:0] tgt_mdeg,
   input  wire logic [ssr_pkg::SPD_W-1:0] speed,
   output logic      [ssr_pkg::POS_W-1:0] next_pos,
   output logic      [ssr_pkg::SPD_W-1:0] next_speed
);

   logic                        below;
   logic [ssr_pkg::POS_W-1:0]   gap_mdeg;
   logic                        arrive;

   always_comb begin
      below    = pos_mdeg < tgt_mdeg;
      gap_mdeg = below ? (tgt_mdeg - pos_mdeg) : (pos_mdeg - tgt_mdeg);
      arrive   = gap_mdeg <= ssr_pkg::POS_W'(speed);
      if (arrive) begin
         next_pos   = tgt_mdeg;
         next_speed = '0;
      end else begin
         next_pos   = below ? (pos_mdeg + ssr_pkg::POS_W'(speed))
                            : (pos_mdeg - ssr_pkg::POS_W'(speed));
         next_speed = speed;
      end
   end

endmodule

`default_nettype wire

// File: src/ssr_scale.sv
// Millidegree rounding and degree-to-pulse-width conversion by reciprocal multiplies.
`timescale 1ns / 1ps
`default_nettype none

module ssr_scale (
   input  wire logic [ssr_pkg::POS_W-1:0]   pos_mdeg,
   output logic      [ssr_pkg::DEG_W-1:0]   round_deg,
   input  wire logic [ssr_pkg::DEG_W-1:0]   deg,
   output logic      [ssr_pkg::PULSE_W-1:0] pwm_high_us
);

   // (pos + 500) / 1000 = ((pos + 500) >> 3) / 125; 33555 / 2**22 ~ 1/125.
   localparam logic [15:0] RECIP_125 = 16'd33555;
   // deg * 100 / 9 folded into one constant: 100 * 58255 / 2**19.
   localparam logic [30:0] PULSE_MUL = 31'd5825500;

   logic [ssr_pkg::POS_W:0]   biased;
   logic [31:0]               round_prod;
   logic [30:0]               pulse_prod;

   always_comb begin
      biased      = {1'b0, pos_mdeg} + (ssr_pkg::POS_W + 1)'(500);
      round_prod  = 32'(biased[ssr_pkg::POS_W:3]) * 32'(RECIP_125);
      round_deg   = round_prod[ssr_pkg::DEG_W+21:22];
      pulse_prod  = 31'(deg) * PULSE_MUL;
      pwm_high_us = ssr_pkg::PULSE_BASE + pulse_prod[30:19];
   end

endmodule

`default_nettype wire

// File: src/servo_slew_rate_ramp.sv
// Top level of the multi-channel servo slew limiter.
//
// Accepts one command item at a time on req_chan and returns zero or more result items on
// rsp_chan. set_now drives a channel's shown angle at once; set_ramp stores a target and a
// speed (speed 0 jumps there immediately); read returns the shown angle; tick advances every
// ramping channel by its speed in millidegrees and reports each channel that moved, with the
// final item of a command marked by last. All per-channel state lives in one memory that is
// read for every channel visited and written back when it changes; an entry never written reads
// as the power-up state (90 degrees, no ramp), so no clearing pass runs after reset.
// Sequence: a set or read on a valid channel passes through memory read, fetch, slew step,
// rounding and write-back, pulse conversion and hand-off to the result register; an
// out-of-range read goes straight to hand-off with no memory access, and an out-of-range
// set is taken and dropped with no result. A tick visits every channel in turn through the
// same steps. A new item is taken once the previous one has been fully handed to the
// result register, which holds one item while the consumer stalls.
`timescale 1ns / 1ps
`default_nettype none

module servo_slew_rate_ramp (
   input  wire logic   clock,
   input  wire logic   reset,
   ssr_req_if.sink     req_chan,
   ssr_rsp_if.source   rsp_chan
);

   // Sequencer state
   ssr_pkg::state_type                state_ff, state_in;

   // Command held for the duration of the item
   ssr_pkg::cmd_type                  cmd_ff;
   logic [ssr_pkg::CHF_W-1:0]         chan_ff;
   logic [ssr_pkg::DEG_W-1:0]         ang_ff;
   logic [ssr_pkg::SPD_W-1:0]         spd_ff;

   // Channel walk and per-channel working registers
   logic [ssr_pkg::CH_W-1:0]          idx_ff;
   logic [ssr_pkg::CNT_W-1:0]         cnt_ff;
   ssr_pkg::word_type                 word_ff;
   logic [ssr_pkg::POS_W-1:0]         tgt_mdeg_ff;
   logic [ssr_pkg::POS_W-1:0]         new_pos_ff;
   logic [ssr_pkg::SPD_W-1:0]         new_spd_ff;
   logic [ssr_pkg::DEG_W-1:0]         deg_ff;
   logic [ssr_pkg::PULSE_W-1:0]       pulse_ff;
   logic                              emit_ff;

   // Copy of "speed is nonzero" per channel, for the last flag of a tick
   logic [ssr_pkg::CHANNELS-1:0]      ramp_ff;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ssr_pkg::CHF_W-1:0]         rsp_channel_ff;
   logic [ssr_pkg::PULSE_W-1:0]       rsp_pulse_ff;
   logic [ssr_pkg::DEG_W-1:0]         rsp_angle_ff;
   logic                              rsp_drive_ff;
   logic                              rsp_last_ff;

   // Control and datapath nets
   logic                              req_take;
   logic                              chan_ok;
   logic [ssr_pkg::DEG_W-1:0]         req_ang_clamped;
   logic                              out_free;
   logic                              emit_now;
   logic                              emit_go;
   logic                              advance;
   logic                              last_walk;
   logic                              later_ramp;
   logic                              is_tick;
   logic                              moved;
   logic                              do_write;
   logic [ssr_pkg::POS_W-1:0]         slew_pos;
   logic [ssr_pkg::SPD_W-1:0]         slew_spd;
   logic [ssr_pkg::DEG_W-1:0]         round_deg;
   logic [ssr_pkg::DEG_W-1:0]         deg_in;
   logic [ssr_pkg::PULSE_W-1:0]       pulse_calc;
   ssr_pkg::mem_ctl_type              mem_ctl;
   ssr_pkg::word_type                 mem_wr;
   ssr_pkg::word_type                 mem_rd;

   ssr_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_data (mem_wr),
      .rd_data (mem_rd)
   );

   ssr_slew u_slew (
      .pos_mdeg   (word_ff.position),
      .tgt_mdeg   (tgt_mdeg_ff),
      .speed      (word_ff.speed),
      .next_pos   (slew_pos),
      .next_speed (slew_spd)
   );

   ssr_scale u_scale (
      .pos_mdeg    (new_pos_ff),
      .round_deg   (round_deg),
      .deg         (deg_ff),
      .pwm_high_us (pulse_calc)
   );

   // Decode of the incoming item
   always_comb begin
      req_take        = req_chan.valid && req_chan.ready;
      chan_ok         = (ssr_pkg::CHF_W + 1)'(req_chan.channel)
                        < (ssr_pkg::CHF_W + 1)'(ssr_pkg::CHANNELS);
      req_ang_clamped = (req_chan.angle > ssr_pkg::MAX_ANGLE) ? ssr_pkg::MAX_ANGLE
                                                              : req_chan.angle;
   end

   // Hand-off and channel-walk conditions
   always_comb begin
      is_tick    = cmd_ff == ssr_pkg::CMD_TICK;
      out_free   = !rsp_valid_ff || rsp_chan.ready;
      emit_now   = emit_ff && (!is_tick || (cnt_ff < ssr_pkg::CNT_W'(ssr_pkg::MAX_RESULTS)));
      emit_go    = (state_ff == ssr_pkg::ST_EMIT) && emit_now && out_free;
      advance    = (state_ff == ssr_pkg::ST_EMIT) && (!emit_now || out_free);
      last_walk  = !is_tick || (idx_ff == ssr_pkg::CH_W'(ssr_pkg::CHANNELS - 1));
      later_ramp = |((ramp_ff >> idx_ff) >> 1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssr_pkg::ST_IDLE: begin
            if (req_take) begin
               if (ssr_pkg::cmd_type'(req_chan.cmd) == ssr_pkg::CMD_TICK || chan_ok) begin
                  state_in = ssr_pkg::ST_READ;
               end else if (ssr_pkg::cmd_type'(req_chan.cmd) == ssr_pkg::CMD_READ) begin
                  state_in = ssr_pkg::ST_EMIT;
               end
            end
         end
         ssr_pkg::ST_READ:  state_in = ssr_pkg::ST_FETCH;
         ssr_pkg::ST_FETCH: state_in = ssr_pkg::ST_STEP;
         ssr_pkg::ST_STEP:  state_in = ssr_pkg::ST_ROUND;
         ssr_pkg::ST_ROUND: state_in = ssr_pkg::ST_PULSE;
         ssr_pkg::ST_PULSE: state_in = ssr_pkg::ST_EMIT;
         ssr_pkg::ST_EMIT: begin
            if (advance) begin
               state_in = last_walk ? ssr_pkg::ST_IDLE : ssr_pkg::ST_READ;
            end
         end
         default: state_in = ssr_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: request ready and memory control
   always_comb begin
      req_chan.ready  = 1'b0;
      mem_ctl.rd_en   = 1'b0;
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.rd_addr = idx_ff;
      mem_ctl.wr_addr = idx_ff;
      unique case (state_ff)
         ssr_pkg::ST_IDLE:  req_chan.ready = 1'b1;
         ssr_pkg::ST_READ:  mem_ctl.rd_en  = 1'b1;
         ssr_pkg::ST_ROUND: mem_ctl.wr_en  = do_write;
         default: ;
      endcase
   end

   // Write-back: a moved ramp, set_now or set_ramp changes the entry; a read does not
   always_comb begin
      moved    = word_ff.speed != '0;
      case (cmd_ff) inside
         ssr_pkg::CMD_TICK:                           do_write = moved;
         ssr_pkg::CMD_SET_NOW, ssr_pkg::CMD_SET_RAMP: do_write = 1'b1;
         default:                                     do_write = 1'b0;
      endcase

      case (cmd_ff)
         ssr_pkg::CMD_TICK:    deg_in = moved ? round_deg : word_ff.shown;
         ssr_pkg::CMD_SET_NOW: deg_in = ang_ff;
         ssr_pkg::CMD_SET_RAMP: deg_in = (spd_ff == '0) ? ang_ff : word_ff.shown;
         default:              deg_in = word_ff.shown;
      endcase

      mem_wr.position = new_pos_ff;
      mem_wr.target   = (cmd_ff == ssr_pkg::CMD_SET_RAMP) ? ang_ff : word_ff.target;
      mem_wr.speed    = new_spd_ff;
      mem_wr.shown    = deg_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssr_pkg::ST_IDLE;
         ramp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_ctl.wr_en) begin
            ramp_ff[idx_ff] <= new_spd_ff != '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = emit_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   // Datapath registers, loaded by sequencer step
   always_ff @(posedge clock) begin
      case (state_ff)
         ssr_pkg::ST_IDLE: begin
            if (req_take) begin
               cmd_ff  <= ssr_pkg::cmd_type'(req_chan.cmd);
               chan_ff <= req_chan.channel;
               ang_ff  <= req_ang_clamped;
               spd_ff  <= req_chan.speed;
               cnt_ff  <= '0;
               idx_ff  <= (ssr_pkg::cmd_type'(req_chan.cmd) == ssr_pkg::CMD_TICK)
                          ? '0 : req_chan.channel[ssr_pkg::CH_W-1:0];
               // Out-of-range read answers zero with no memory access
               deg_ff  <= '0;
               emit_ff <= 1'b1;
            end
         end
         ssr_pkg::ST_FETCH: begin
            word_ff     <= mem_rd;
            tgt_mdeg_ff <= ssr_pkg::mdeg_of(mem_rd.target);
         end
         ssr_pkg::ST_STEP: begin
            new_pos_ff <= word_ff.position;
            new_spd_ff <= word_ff.speed;
            emit_ff    <= 1'b1;
            case (cmd_ff)
               ssr_pkg::CMD_TICK: begin
                  new_pos_ff <= moved ? slew_pos : word_ff.position;
                  new_spd_ff <= slew_spd;
                  emit_ff    <= moved;
               end
               ssr_pkg::CMD_SET_RAMP: begin
                  if (spd_ff == '0) begin
                     new_pos_ff <= ssr_pkg::mdeg_of(ang_ff);
                     new_spd_ff <= '0;
                  end else begin
                     new_spd_ff <= spd_ff;
                     emit_ff    <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
         ssr_pkg::ST_ROUND: begin
            deg_ff <= deg_in;
         end
         ssr_pkg::ST_PULSE: begin
            pulse_ff <= pulse_calc;
         end
         ssr_pkg::ST_EMIT: begin
            if (emit_go) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (advance && !last_walk) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Result payload: load on hand-off, hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_channel_ff <= is_tick ? ssr_pkg::CHF_W'(idx_ff) : chan_ff;
         rsp_angle_ff   <= deg_ff;
         rsp_drive_ff   <= cmd_ff != ssr_pkg::CMD_READ;
         rsp_pulse_ff   <= (cmd_ff == ssr_pkg::CMD_READ) ? '0 : pulse_ff;
         rsp_last_ff    <= !is_tick || !later_ramp
                           || (cnt_ff == ssr_pkg::CNT_W'(ssr_pkg::MAX_RESULTS - 1));
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_channel = rsp_channel_ff;
   assign rsp_chan.pwm_high_us = rsp_pulse_ff;
   assign rsp_chan.out_angle   = rsp_angle_ff;
   assign rsp_chan.drive       = rsp_drive_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/ssr_checker.sv
// Port-level checker for the servo slew limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssr_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ssr_pkg::CHF_W-1:0]   rsp_channel,
   input wire logic [ssr_pkg::PULSE_W-1:0] rsp_pulse,
   input wire logic [ssr_pkg::DEG_W-1:0]   rsp_angle,
   input wire logic                        rsp_drive,
   input wire logic                        rsp_last
);

   // Coming out of reset the block is empty and open for an item.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel) && $stable(rsp_pulse)
                                  && $stable(rsp_angle) && $stable(rsp_drive)
                                  && $stable(rsp_last))
      else $error("stalled result changed");

   // Read answers carry no pulse width.
   a_read_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive |-> rsp_pulse == '0)
      else $error("read answer with pulse width");

   // Drive results stay inside the servo range.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive |-> rsp_angle <= ssr_pkg::MAX_ANGLE
                                 && rsp_pulse >= 12'd500 && rsp_pulse <= 12'd2500)
      else $error("drive result out of range");

   // No new item is taken while a non-final result is still waiting.
   a_no_take_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !(req_valid && req_ready))
      else $error("item accepted in the middle of a result burst");

endmodule

bind servo_slew_rate_ramp ssr_checker u_ssr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_channel (rsp_chan.out_channel),
   .rsp_pulse   (rsp_chan.pwm_high_us),
   .rsp_angle   (rsp_chan.out_angle),
   .rsp_drive   (rsp_chan.drive),
   .rsp_last    (rsp_chan.last)
);

`default_nettype wire
